FILE: design/sctoa_pkg.sv
// Package: scan code constants, flag types and the key map table for the scan code translator.
package sctoa_pkg;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned AsciiW = 7;
  localparam int unsigned IdxW   = 7;

  // Modifier press codes; release is the press code with bit 7 set
  localparam logic [CodeW-1:0] ScShiftL     = 8'd42;
  localparam logic [CodeW-1:0] ScShiftR     = 8'd54;
  localparam logic [CodeW-1:0] ScShiftLRel  = 8'd170;
  localparam logic [CodeW-1:0] ScShiftRRel  = 8'd182;
  localparam logic [CodeW-1:0] ScCtrlA      = 8'd56;
  localparam logic [CodeW-1:0] ScCtrlB      = 8'd58;
  localparam logic [CodeW-1:0] ScCtrlARel   = 8'd184;
  localparam logic [CodeW-1:0] ScCtrlBRel   = 8'd186;
  localparam logic [CodeW-1:0] ScAltA       = 8'd113;
  localparam logic [CodeW-1:0] ScAltB       = 8'd114;
  localparam logic [CodeW-1:0] ScAltARel    = 8'd241;
  localparam logic [CodeW-1:0] ScAltBRel    = 8'd242;
  localparam logic [CodeW-1:0] ScCapsLock   = 8'd29;

  // Lower-case letter range and the control code offset
  localparam logic [AsciiW-1:0] AsciiLowA   = 7'd97;
  localparam logic [AsciiW-1:0] AsciiLowZ   = 7'd122;
  localparam logic [AsciiW-1:0] CtrlOffset  = 7'd96;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } sctoa_flags_t;

  // One key map entry: shifted character over plain character
  typedef struct packed {
    logic [AsciiW-1:0] shifted;
    logic [AsciiW-1:0] plain;
  } sctoa_entry_t;

  function automatic sctoa_entry_t sctoa_keymap(input logic [IdxW-1:0] idx);
    sctoa_entry_t e;
    e = '0;
    unique case (idx)
      7'd2:   e = '{7'd33,  7'd49};
      7'd3:   e = '{7'd64,  7'd50};
      7'd4:   e = '{7'd35,  7'd51};
      7'd5:   e = '{7'd36,  7'd52};
      7'd6:   e = '{7'd37,  7'd53};
      7'd7:   e = '{7'd94,  7'd54};
      7'd8:   e = '{7'd38,  7'd55};
      7'd9:   e = '{7'd42,  7'd56};
      7'd10:  e = '{7'd40,  7'd57};
      7'd11:  e = '{7'd41,  7'd48};
      7'd12:  e = '{7'd95,  7'd45};
      7'd13:  e = '{7'd43,  7'd61};
      7'd14:  e = '{7'd8,   7'd8};
      7'd15:  e = '{7'd9,   7'd9};
      7'd16:  e = '{7'd81,  7'd113};
      7'd17:  e = '{7'd87,  7'd119};
      7'd18:  e = '{7'd69,  7'd101};
      7'd19:  e = '{7'd82,  7'd114};
      7'd20:  e = '{7'd84,  7'd116};
      7'd21:  e = '{7'd89,  7'd121};
      7'd22:  e = '{7'd85,  7'd117};
      7'd23:  e = '{7'd73,  7'd105};
      7'd24:  e = '{7'd79,  7'd111};
      7'd25:  e = '{7'd80,  7'd112};
      7'd26:  e = '{7'd123, 7'd91};
      7'd27:  e = '{7'd125, 7'd93};
      7'd28:  e = '{7'd10,  7'd10};
      7'd30:  e = '{7'd65,  7'd97};
      7'd31:  e = '{7'd83,  7'd115};
      7'd32:  e = '{7'd68,  7'd100};
      7'd33:  e = '{7'd70,  7'd102};
      7'd34:  e = '{7'd71,  7'd103};
      7'd35:  e = '{7'd72,  7'd104};
      7'd36:  e = '{7'd74,  7'd106};
      7'd37:  e = '{7'd75,  7'd107};
      7'd38:  e = '{7'd76,  7'd108};
      7'd39:  e = '{7'd58,  7'd59};
      7'd40:  e = '{7'd34,  7'd39};
      7'd41:  e = '{7'd126, 7'd96};
      7'd44:  e = '{7'd90,  7'd122};
      7'd45:  e = '{7'd88,  7'd120};
      7'd46:  e = '{7'd67,  7'd99};
      7'd47:  e = '{7'd86,  7'd118};
      7'd48:  e = '{7'd66,  7'd98};
      7'd49:  e = '{7'd78,  7'd110};
      7'd50:  e = '{7'd77,  7'd109};
      7'd51:  e = '{7'd60,  7'd44};
      7'd52:  e = '{7'd62,  7'd46};
      7'd53:  e = '{7'd63,  7'd47};
      7'd57:  e = '{7'd32,  7'd32};
      7'd83:  e = '{7'd127, 7'd127};
      7'd100: e = '{7'd27,  7'd27};
      7'd117: e = '{7'd124, 7'd92};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

FILE: design/sctoa_if.sv
// Interfaces: scan code input channel and translated character output channel.
interface sctoa_in_if;
  import sctoa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CodeW-1:0]  scancode;

  modport source (output valid, output scancode, input ready);
  modport sink   (input valid, input scancode, output ready);
endinterface

interface sctoa_out_if;
  import sctoa_pkg::*;
  logic              valid;
  logic              ready;
  logic [AsciiW-1:0] ascii;
  logic              shift_active;
  logic              ctrl_active;
  logic              alt_active;
  logic              caps_active;

  modport source (output valid, output ascii, output shift_active, output ctrl_active,
                  output alt_active, output caps_active, input ready);
  modport sink   (input valid, input ascii, input shift_active, input ctrl_active,
                  input alt_active, input caps_active, output ready);
endinterface

FILE: design/sctoa_keymap.sv
// Key map ROM: registered lookup of plain and shifted characters for a make code.
module sctoa_keymap
  import sctoa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [IdxW-1:0]   rd_idx_i,
  output sctoa_entry_t      rd_data_o
);

  sctoa_entry_t data_q;

  // Read one entry per enabled cycle, hold otherwise
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= sctoa_keymap(rd_idx_i);
    end
  end

  assign rd_data_o = data_q;

endmodule

FILE: design/scancode_to_ascii_translator.sv
// Top level: scan code to ASCII translator with modifier and caps lock tracking.
//
// Accepts one scan code per cycle while the output is not stalled, and returns
// one result per code, in order. The key map ROM has a registered read, and the
// result then sits in an output register that lets the next code be taken while
// a result waits. Modifier and caps flags update at the input transfer, and each
// code is translated and reported with the flags as that code itself leaves
// them. No clearing pass after reset.
module scancode_to_ascii_translator
  import sctoa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sctoa_in_if.sink    in_i,
  sctoa_out_if.source out_o
);

  sctoa_flags_t      flags_q, flags_d;
  sctoa_flags_t      s1_flags_q;
  logic              s1_valid_q;
  logic              s1_release_q;
  sctoa_entry_t      rom_data;

  logic              out_valid_q;
  logic [AsciiW-1:0] out_ascii_q, out_ascii_d;
  sctoa_flags_t      out_flags_q;

  logic              out_free, s1_adv, in_fire;
  logic [CodeW-1:0]  code;
  logic              is_letter, up;
  logic [AsciiW-1:0] ch;

  // Handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign code       = in_i.scancode;

  // Update modifier flags from the incoming code
  always_comb begin
    flags_d = flags_q;
    if (code == ScShiftL || code == ScShiftR)       flags_d.shift = 1'b1;
    if (code == ScShiftLRel || code == ScShiftRRel) flags_d.shift = 1'b0;
    if (code == ScCtrlA || code == ScCtrlB)         flags_d.ctrl  = 1'b1;
    if (code == ScCtrlARel || code == ScCtrlBRel)   flags_d.ctrl  = 1'b0;
    if (code == ScAltA || code == ScAltB)           flags_d.alt   = 1'b1;
    if (code == ScAltARel || code == ScAltBRel)     flags_d.alt   = 1'b0;
    if (code == ScCapsLock)                         flags_d.caps  = !flags_q.caps;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (in_fire) begin
      flags_q <= flags_d;
    end
  end

  // Look up the make code
  sctoa_keymap u_keymap (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_idx_i  (code[IdxW-1:0]),
    .rd_data_o (rom_data)
  );

  // Stage 1: hold flag snapshot and release bit alongside the ROM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_flags_q   <= flags_d;
      s1_release_q <= code[CodeW-1];
    end
  end

  // Pick plain or shifted character, zero it for a release, then apply ctrl
  always_comb begin
    is_letter = (rom_data.plain >= AsciiLowA) && (rom_data.plain <= AsciiLowZ);
    up        = is_letter ? (s1_flags_q.shift ^ s1_flags_q.caps) : s1_flags_q.shift;
    ch        = up ? rom_data.shifted : rom_data.plain;
    if (s1_release_q) begin
      ch = '0;
    end
    out_ascii_d = ch;
    if (s1_flags_q.ctrl && ch >= AsciiLowA && ch <= AsciiLowZ) begin
      out_ascii_d = ch - CtrlOffset;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_ascii_q <= out_ascii_d;
      out_flags_q <= s1_flags_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.ascii        = out_ascii_q;
  assign out_o.shift_active = out_flags_q.shift;
  assign out_o.ctrl_active  = out_flags_q.ctrl;
  assign out_o.alt_active   = out_flags_q.alt;
  assign out_o.caps_active  = out_flags_q.caps;

endmodule

FILE: design/sctoa_checker.sv
// Checker: port-level properties of the scan code translator, bound to the top level.
module sctoa_checker
  import sctoa_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [AsciiW-1:0] out_ascii_i,
  input logic              out_shift_i,
  input logic              out_ctrl_i,
  input logic              out_alt_i,
  input logic              out_caps_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_ascii_i)
      && $stable(out_shift_i) && $stable(out_ctrl_i) && $stable(out_alt_i)
      && $stable(out_caps_i))
    else $error("stalled result changed");

  // Ctrl turns every lower-case letter into a control code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ctrl_i |-> !(out_ascii_i >= 7'd97 && out_ascii_i <= 7'd122))
    else $error("lower-case letter with ctrl held");

  // Upper-case letters need shift XOR caps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ascii_i >= 7'd65 && out_ascii_i <= 7'd90 |-> out_shift_i != out_caps_i)
    else $error("upper-case letter without shift xor caps");

  // Control codes 11 to 26, above backspace, tab and enter, need ctrl
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ascii_i >= 7'd11 && out_ascii_i <= 7'd26 |-> out_ctrl_i)
    else $error("control code without ctrl held");

endmodule

bind scancode_to_ascii_translator sctoa_checker u_sctoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_ascii_i (out_o.ascii),
  .out_shift_i (out_o.shift_active),
  .out_ctrl_i  (out_o.ctrl_active),
  .out_alt_i   (out_o.alt_active),
  .out_caps_i  (out_o.caps_active)
);
